FILE: rtl/char_cell_pixel_buffer_assert.svh
// Assertion macros for the character-cell pixel buffer.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef CHAR_CELL_PIXEL_BUFFER_ASSERT_SVH
`define CHAR_CELL_PIXEL_BUFFER_ASSERT_SVH

// Same-cycle implication.
`define CCPB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CCPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ccpb_pkg.sv
// ----------------------------------------------------------------------------
// ccpb_pkg
// Shared types, constants and coordinate decode for the character-cell
// pixel buffer.
// ----------------------------------------------------------------------------
package ccpb_pkg;

    localparam int NUM_GLYPHS = 8;
    localparam int GLYPH_H    = 8;
    localparam int GLYPH_W    = 5;
    localparam int GLYPH_IW   = $clog2(NUM_GLYPHS);
    localparam int ROW_IW     = $clog2(GLYPH_H);
    localparam int ADDR_W     = GLYPH_IW + ROW_IW;
    localparam int DEPTH      = NUM_GLYPHS * GLYPH_H;

    // x / 20 as (x * 205) >> 12, exact for every 8-bit x
    localparam logic [15:0] DIV20_MUL   = 16'd205;
    localparam int          DIV20_SHIFT = 12;

    typedef enum logic [2:0] {
        CMD_SET       = 3'd0,
        CMD_CLR       = 3'd1,
        CMD_READ      = 3'd2,
        CMD_CLEAR_ALL = 3'd3,
        CMD_FLUSH     = 3'd4
    } cmd_t;

    typedef enum logic [0:0] {
        KIND_READ   = 1'b0,
        KIND_UPLOAD = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PX_RD,
        ST_PX_UPD,
        ST_FL_SCAN,
        ST_FL_RD,
        ST_FL_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // input transaction taken
        logic rd_en;      // issue store read at current address
        logic px_write;   // write back updated pixel row
        logic px_out;     // load read answer into output register
        logic clear_all;  // drop every row, mark nonzero glyphs dirty
        logic fl_out;     // load upload row into output register, advance row
        logic g_inc;      // advance flush glyph
        logic dirty_clr;  // flush done, clear all dirty marks
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic g_dirty;    // current glyph is dirty
        logic g_max;      // current glyph is the highest one
        logic row_max;    // current row is the glyph's bottom row
        logic fl_final;   // no dirty glyph above the current one
    } dp_status_t;

    typedef struct packed {
        logic [GLYPH_IW-1:0] glyph;
        logic [ROW_IW-1:0]   row;
        logic [GLYPH_W-1:0]  mask;
    } pix_loc_t;

    function automatic pix_loc_t decode_pos(logic [7:0] x, logic [7:0] y);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  q20;
        logic [7:0]  rem8;
        logic [4:0]  r;
        logic [1:0]  cx;
        logic [4:0]  cx5;
        logic [4:0]  off5;
        pix_loc_t    loc;
        prod = {8'd0, x} * DIV20_MUL;
        q    = prod[DIV20_SHIFT +: 4];
        q20  = {q, 4'b0000} + {2'b00, q, 2'b00};
        rem8 = x - q20;
        r    = rem8[4:0];
        if (r >= 5'd15) begin
            cx = 2'd3;
        end else if (r >= 5'd10) begin
            cx = 2'd2;
        end else if (r >= 5'd5) begin
            cx = 2'd1;
        end else begin
            cx = 2'd0;
        end
        cx5       = {1'b0, cx, 2'b00} + {3'b000, cx};
        off5      = r - cx5;
        loc.glyph = {y[3], cx};
        loc.row   = y[2:0];
        loc.mask  = 5'b10000 >> off5[2:0];
        return loc;
    endfunction

endpackage

FILE: rtl/ccpb_ctrl.sv
// ----------------------------------------------------------------------------
// ccpb_ctrl
// Command sequencer: pixel read-modify-write, pixel read, clear all and
// the flush walk over dirty glyphs.
// ----------------------------------------------------------------------------
module ccpb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             cmd,
    input  ccpb_pkg::dp_status_t   sts,
    output ccpb_pkg::ctrl_cmd_t    ctl
);

    ccpb_pkg::state_t state_reg;
    ccpb_pkg::state_t state_next;
    logic             accept;
    logic             px_is_read_reg;

    assign in_ready = (state_reg == ccpb_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccpb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccpb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        ccpb_pkg::CMD_SET, ccpb_pkg::CMD_CLR, ccpb_pkg::CMD_READ:
                            state_next = ccpb_pkg::ST_PX_RD;
                        ccpb_pkg::CMD_FLUSH:
                            state_next = ccpb_pkg::ST_FL_SCAN;
                        default:
                            state_next = ccpb_pkg::ST_IDLE;
                    endcase
                end
            end
            ccpb_pkg::ST_PX_RD:
                state_next = ccpb_pkg::ST_PX_UPD;
            ccpb_pkg::ST_PX_UPD:
            begin
                // set and clear finish at once; a read waits for the output slot
                if (!sts.out_free && !ctl.px_write)
                begin
                    state_next = ccpb_pkg::ST_PX_UPD;
                end
                else
                begin
                    state_next = ccpb_pkg::ST_IDLE;
                end
            end
            ccpb_pkg::ST_FL_SCAN:
            begin
                if (sts.g_dirty)
                begin
                    state_next = ccpb_pkg::ST_FL_RD;
                end
                else if (sts.g_max)
                begin
                    state_next = ccpb_pkg::ST_IDLE;
                end
            end
            ccpb_pkg::ST_FL_RD:
                state_next = ccpb_pkg::ST_FL_OUT;
            ccpb_pkg::ST_FL_OUT:
            begin
                if (sts.out_free)
                begin
                    if (!sts.row_max)
                    begin
                        state_next = ccpb_pkg::ST_FL_RD;
                    end
                    else if (sts.fl_final)
                    begin
                        state_next = ccpb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = ccpb_pkg::ST_FL_SCAN;
                    end
                end
            end
            default:
                state_next = ccpb_pkg::ST_IDLE;
        endcase
    end

    // Remember whether the pixel op in flight is a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_is_read_reg <= 1'b0;
        end
        else if (accept)
        begin
            px_is_read_reg <= (cmd == ccpb_pkg::CMD_READ);
        end
    end

    always_comb
    begin
        ctl           = '0;
        ctl.load      = accept;
        ctl.clear_all = accept && (cmd == ccpb_pkg::CMD_CLEAR_ALL);
        case (state_reg)
            ccpb_pkg::ST_PX_RD:
                ctl.rd_en = 1'b1;
            ccpb_pkg::ST_PX_UPD:
            begin
                ctl.px_write = !px_is_read_reg;
                ctl.px_out   = px_is_read_reg && sts.out_free;
            end
            ccpb_pkg::ST_FL_SCAN:
            begin
                ctl.g_inc     = !sts.g_dirty && !sts.g_max;
                ctl.dirty_clr = !sts.g_dirty && sts.g_max;
            end
            ccpb_pkg::ST_FL_RD:
                ctl.rd_en = 1'b1;
            ccpb_pkg::ST_FL_OUT:
            begin
                ctl.fl_out    = sts.out_free;
                ctl.g_inc     = sts.out_free && sts.row_max && !sts.fl_final;
                ctl.dirty_clr = sts.out_free && sts.row_max && sts.fl_final;
            end
            default:
                ctl.rd_en = 1'b0;
        endcase
    end

endmodule

FILE: rtl/ccpb_dp.sv
// ----------------------------------------------------------------------------
// ccpb_dp
// Glyph row store, row nonzero flags, dirty marks, flush counters and the
// output register.
// ----------------------------------------------------------------------------
module ccpb_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [2:0]                          cmd,
    input  logic [7:0]                          pos_x,
    input  logic [7:0]                          pos_y,
    input  ccpb_pkg::ctrl_cmd_t                 ctl,
    output ccpb_pkg::dp_status_t                sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                kind,
    output logic                                pixel_value,
    output logic [2:0]                          glyph_index,
    output logic [2:0]                          glyph_row,
    output logic [4:0]                          row_bits,
    output logic                                last
);

    localparam int GW = ccpb_pkg::GLYPH_IW;
    localparam int RW = ccpb_pkg::ROW_IW;
    localparam int AW = ccpb_pkg::ADDR_W;
    localparam int NG = ccpb_pkg::NUM_GLYPHS;
    localparam int GH = ccpb_pkg::GLYPH_H;
    localparam int PW = ccpb_pkg::GLYPH_W;

    logic [PW-1:0]          mem [0:ccpb_pkg::DEPTH-1];
    logic [PW-1:0]          rd_data_reg;
    logic                   rd_nz_reg;
    logic [ccpb_pkg::DEPTH-1:0] row_nz_reg;
    logic [ccpb_pkg::DEPTH-1:0] row_nz_next;
    logic [NG-1:0]          dirty_reg;
    logic [NG-1:0]          dirty_next;
    logic [GW-1:0]          g_reg;
    logic [RW-1:0]          row_reg;
    logic [PW-1:0]          mask_reg;
    logic                   op_set_reg;
    logic                   out_valid_reg;
    logic                   kind_reg;
    logic                   pixel_reg;
    logic [GW-1:0]          gi_reg;
    logic [RW-1:0]          gr_reg;
    logic [PW-1:0]          bits_reg;
    logic                   last_reg;

    ccpb_pkg::pix_loc_t     loc;
    logic [AW-1:0]          addr;
    logic [PW-1:0]          cur_row;
    logic [PW-1:0]          new_row;
    logic                   changed;
    logic [NG-1:0]          glyph_nz;
    logic [NG-1:0]          above_mask;

    assign loc        = ccpb_pkg::decode_pos(pos_x, pos_y);
    assign addr       = {g_reg, row_reg};
    // a row never written since reset or clear reads as zero
    assign cur_row    = rd_nz_reg ? rd_data_reg : '0;
    assign new_row    = op_set_reg ? (cur_row | mask_reg) : (cur_row & ~mask_reg);
    assign changed    = (new_row != cur_row);
    assign above_mask = {{(NG-1){1'b1}}, 1'b0} << g_reg;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            glyph_nz[g] = |row_nz_reg[g*GH +: GH];
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.g_dirty  = dirty_reg[g_reg];
    assign sts.g_max    = (g_reg == GW'(NG - 1));
    assign sts.row_max  = (row_reg == RW'(GH - 1));
    assign sts.fl_final = ((dirty_reg & above_mask) == '0);

    always_ff @(posedge clk)
    begin
        if (ctl.px_write)
        begin
            mem[addr] <= new_row;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
            rd_nz_reg   <= row_nz_reg[addr];
        end
    end

    always_comb
    begin
        row_nz_next = row_nz_reg;
        dirty_next  = dirty_reg;
        if (ctl.clear_all)
        begin
            row_nz_next = '0;
            dirty_next  = dirty_reg | glyph_nz;
        end
        else if (ctl.px_write)
        begin
            row_nz_next[addr] = |new_row;
            if (changed)
            begin
                dirty_next[g_reg] = 1'b1;
            end
        end
        else if (ctl.dirty_clr)
        begin
            dirty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_nz_reg    <= '0;
            dirty_reg     <= '1;
            g_reg         <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_nz_reg <= row_nz_next;
            dirty_reg  <= dirty_next;
            if (ctl.load)
            begin
                if (cmd == ccpb_pkg::CMD_FLUSH)
                begin
                    g_reg   <= '0;
                    row_reg <= '0;
                end
                else
                begin
                    g_reg   <= loc.glyph;
                    row_reg <= loc.row;
                end
            end
            else
            begin
                if (ctl.g_inc)
                begin
                    g_reg <= g_reg + GW'(1);
                end
                if (ctl.fl_out)
                begin
                    row_reg <= row_reg + RW'(1);
                end
            end
            if (ctl.px_out || ctl.fl_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mask_reg   <= loc.mask;
            op_set_reg <= (cmd == ccpb_pkg::CMD_SET);
        end
        if (ctl.px_out)
        begin
            kind_reg  <= ccpb_pkg::KIND_READ;
            pixel_reg <= |(cur_row & mask_reg);
            gi_reg    <= '0;
            gr_reg    <= '0;
            bits_reg  <= '0;
            last_reg  <= 1'b1;
        end
        else if (ctl.fl_out)
        begin
            kind_reg  <= ccpb_pkg::KIND_UPLOAD;
            pixel_reg <= 1'b0;
            gi_reg    <= g_reg;
            gr_reg    <= row_reg;
            bits_reg  <= cur_row;
            last_reg  <= sts.row_max && sts.fl_final;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign pixel_value = pixel_reg;
    assign glyph_index = gi_reg;
    assign glyph_row   = gr_reg;
    assign row_bits    = bits_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/char_cell_pixel_buffer.sv
// ----------------------------------------------------------------------------
// char_cell_pixel_buffer
// 20 x 16 one-bit pixel buffer held as eight 5 x 8 glyphs with per-glyph
// dirty marks; set, clear, read, clear-all and flush commands.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid/in_ready   | cmd, pos_x, pos_y
//   out     | output    | out_valid/out_ready | kind, pixel_value, glyph_index,
//           |           |                     | glyph_row, row_bits, last
//
// Set and clear pixel run accept, store read and write back; read pixel
// runs accept and store read, then loads the output register once it is free;
// clear all and unused codes end with the accept. A flush accepts, scans the
// glyphs in order and, for each dirty glyph, reads and uploads every row, a
// store read then an output step per row as the single store read port is
// registered; a stalled output register adds its wait.
// Reset clears the per-row nonzero flags at once, so the store reads as
// all zero right after reset with no clearing pass; all glyphs start dirty.
// A stalled output holds the walk; the next transaction is taken as soon as
// the last result is in the output register.
// ----------------------------------------------------------------------------
`include "char_cell_pixel_buffer_assert.svh"

module char_cell_pixel_buffer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic       pixel_value,
    output logic [2:0] glyph_index,
    output logic [2:0] glyph_row,
    output logic [4:0] row_bits,
    output logic       last
);

    // command and status buses between sequencer and datapath
    ccpb_pkg::ctrl_cmd_t  ctl;
    ccpb_pkg::dp_status_t sts;

    ccpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts),
        .ctl      (ctl)
    );

    ccpb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .ctl         (ctl),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .pixel_value (pixel_value),
        .glyph_index (glyph_index),
        .glyph_row   (glyph_row),
        .row_bits    (row_bits),
        .last        (last)
    );

    // no new transaction while the store is busy with the current one
    `CCPB_ASSERT_IMPLY(a_busy_blocks_input, ctl.rd_en || ctl.px_write || ctl.fl_out, !in_ready, "input taken while store busy")
    // results only enter a free output register
    `CCPB_ASSERT_IMPLY(a_out_load_free, ctl.px_out || ctl.fl_out, sts.out_free, "result loaded over a pending one")
    // the final upload row of a flush returns the block to idle
    `CCPB_ASSERT_NEXT(a_flush_end_idle, ctl.fl_out && sts.row_max && sts.fl_final, in_ready, "flush did not end after last row")

endmodule
